@@ sv/fab_pkg.sv @@
// shared types, constants and a helper function of the frame bitmap allocator
package fab_pkg;

    localparam int DEF_NUM_FRAMES = 4096;
    localparam int FRAME_W        = 12;
    localparam int WORD_BITS      = 32;
    localparam int WORD_SHIFT     = 5;
    localparam int MAX_WORDS      = (1 << FRAME_W) / WORD_BITS;
    localparam int GRP_BITS       = 16;
    localparam int GRP_SHIFT      = 4;
    localparam int IN_DATA_W      = 16;
    localparam int OUT_DATA_W     = 16;

    typedef enum logic [1:0] {
        REQ_MARK_USED = 2'd0,
        REQ_MARK_FREE = 2'd1,
        REQ_TEST      = 2'd2,
        REQ_FIND      = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND_SEL,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load_req;
        logic find_read;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic in_is_find;
        logic out_busy;
    } status_t;

    // index of the lowest set bit, zero when no bit is set
    function automatic logic [4:0] lowest_set(input logic [31:0] x);
        logic [31:0] onehot;
        logic [4:0]  idx;
        onehot = x & (~x + 32'd1);
        idx    = '0;
        for (int k = 0; k < 5; k++)
        begin
            for (int i = 0; i < 32; i++)
            begin
                if (((i >> k) & 1) == 1)
                begin
                    idx[k] = idx[k] | onehot[i];
                end
            end
        end
        return idx;
    endfunction

endpackage

@@ sv/fab_ctrl.sv @@
// request sequencer of the frame bitmap allocator
module fab_ctrl
    import fab_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = status.in_is_find ? ST_FIND_SEL : ST_EXEC;
                end
            end
            ST_FIND_SEL:
            begin
                cmd.find_read = 1'b1;
                state_next    = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/fab_datapath.sv @@
// bitmap memory, not-full summary search and result register
module fab_datapath
    import fab_pkg::*;
#(
    parameter int NUM_FRAMES = DEF_NUM_FRAMES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  cmd_t                  cmd,
    output status_t               status
);

    localparam int NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH     = (NUM_WORDS < MAX_WORDS) ? NUM_WORDS : MAX_WORDS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NG        = (DEPTH + GRP_BITS - 1) / GRP_BITS;
    localparam int GIW       = (NG > 1) ? $clog2(NG) : 1;
    localparam int SUMW      = NG * GRP_BITS;
    localparam logic [31:0] NF_U       = 32'(NUM_FRAMES);
    localparam logic        EXTRA_FREE = (NUM_FRAMES > DEPTH * WORD_BITS);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     vld_reg;
    logic [DEPTH-1:0]     notfull_reg;

    req_t                 req_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [NG-1:0]        grp_any_reg;
    logic [GRP_SHIFT-1:0] grp_pos_reg [NG];
    logic [AW-1:0]        sel_word_reg;
    logic                 sel_any_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rvld_reg;
    logic                 out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [FRAME_W-1:0]   in_frame;
    logic [SUMW-1:0]      sum_pad;
    logic [4:0]           gsel_full;
    logic [GIW-1:0]       gsel;
    logic [AW-1:0]        sel_word_next;
    logic                 sel_any_next;
    logic                 rd_en;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;

    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] new_word;
    logic                 in_range;
    logic                 wr_en;
    logic [4:0]           lc;
    logic [31:0]          cand;
    logic                 res_bit;
    logic [FRAME_W-1:0]   res_free;
    logic                 res_found;

    assign in_frame          = s_tdata[FRAME_W-1:0];
    assign status.in_is_find = (req_t'(s_tuser) == REQ_FIND);
    assign status.out_busy   = out_valid_reg && !m_tready;
    assign m_tvalid          = out_valid_reg;
    assign m_tdata           = out_data_reg;

    // two-level search over the not-full summary
    assign sum_pad       = SUMW'(notfull_reg);
    assign gsel_full     = lowest_set(32'(grp_any_reg));
    assign gsel          = gsel_full[GIW-1:0];
    assign sel_word_next = AW'((32'(gsel) << GRP_SHIFT) | 32'(grp_pos_reg[gsel]));
    assign sel_any_next  = |grp_any_reg;

    assign rd_en = cmd.load_req || cmd.find_read;
    assign raddr = cmd.load_req ? in_frame[WORD_SHIFT +: AW] : sel_word_next;
    assign waddr = frame_reg[WORD_SHIFT +: AW];

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg   <= req_t'(s_tuser);
            frame_reg <= in_frame;
            for (int g = 0; g < NG; g++)
            begin
                grp_any_reg[g] <= |sum_pad[g*GRP_BITS +: GRP_BITS];
                grp_pos_reg[g] <= GRP_SHIFT'(lowest_set(32'(sum_pad[g*GRP_BITS +: GRP_BITS])));
            end
        end
        if (cmd.find_read)
        begin
            sel_word_reg <= sel_word_next;
            sel_any_reg  <= sel_any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
            rvld_reg  <= vld_reg[raddr];
        end
        if (wr_en)
        begin
            mem[waddr] <= new_word;
        end
    end

    always_comb
    begin
        word      = rvld_reg ? rdata_reg : '0;
        bit_mask  = 32'd1 << frame_reg[WORD_SHIFT-1:0];
        in_range  = (32'(frame_reg) < NF_U);
        lc        = lowest_set(~word);
        cand      = (32'(sel_word_reg) << WORD_SHIFT) | 32'(lc);
        new_word  = word;
        wr_en     = 1'b0;
        res_bit   = 1'b0;
        res_free  = '0;
        res_found = 1'b0;
        unique case (req_reg)
            REQ_MARK_USED:
            begin
                new_word = word | bit_mask;
                wr_en    = cmd.finish && in_range;
            end
            REQ_MARK_FREE:
            begin
                new_word = word & ~bit_mask;
                wr_en    = cmd.finish && in_range;
            end
            REQ_TEST:
            begin
                res_bit = in_range && ((word & bit_mask) != '0);
            end
            REQ_FIND:
            begin
                if (sel_any_reg)
                begin
                    res_found = (cand < NF_U);
                    res_free  = res_found ? cand[FRAME_W-1:0] : '0;
                end
                else
                begin
                    res_found = EXTRA_FREE;
                end
            end
            default:
            begin
                new_word = word;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            notfull_reg   <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[waddr]     <= 1'b1;
                notfull_reg[waddr] <= (new_word != '1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= OUT_DATA_W'({res_found, res_free, res_bit});
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !m_tready))
        else $error("result register overwritten while still held");

    a_rd_wr_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("bitmap read and write in the same cycle");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("result raised without a finished request");

    a_find_sel_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.find_read |=> !cmd.find_read && !cmd.load_req)
        else $error("find word read not followed by result step");

endmodule

@@ sv/frame_bitmap_allocator.sv @@
// top level of the frame bitmap allocator: sequencer plus bitmap datapath
// mark and test: the bitmap word is read at the accepting edge, then ST_EXEC registers the result and m_tvalid
// find: the summary group stage is registered at accept, ST_FIND_SEL reads the chosen word, then ST_EXEC
// throughput: a request is accepted only in ST_IDLE, so none is taken before the previous one finishes,
//   and ST_EXEC holds while m_tready is low and the result register is still full
// reset: word valid bits clear and the not-full summary sets at once, all frames free
module frame_bitmap_allocator
    import fab_pkg::*;
#(
    parameter int NUM_FRAMES = DEF_NUM_FRAMES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // frame_index[11:0], zero [15:12]
    input  logic [1:0]            s_tuser,   // req_type[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // bit_value[0], free_frame[12:1], found[13]
);

    cmd_t    cmd;
    status_t status;

    fab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fab_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
